// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, masked while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, masked while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/rgbhsi_pkg.sv
// Shared widths and constants for the RGB to HSI converter.
`default_nettype none
package rgbhsi_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam int ANG_BITS     = 20;
    localparam int CW           = 28;   // CORDIC x/y width
    localparam int ZW           = 30;   // angle accumulator width
    localparam int DIV_STEPS    = 25;   // quotient bits per divide
    localparam int NUM_W        = 35;   // dividend width
    localparam int DEN_W        = NUM_W - DIV_STEPS;
    localparam int HUE_W        = 15;
    localparam int FRAC_W       = 17;

    localparam logic [25:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058,
        26'd1876857, 26'd938658, 26'd469357, 26'd234682, 26'd117342,
        26'd58671, 26'd29335, 26'd14668, 26'd7334, 26'd3667, 26'd1833,
        26'd917, 26'd458, 26'd229, 26'd115, 26'd57, 26'd29, 26'd14, 26'd7
    };

    typedef logic signed [CW-1:0] cord_t;
    typedef logic signed [ZW-1:0] ang_t;
endpackage
`default_nettype wire

// File: rtl/rgbhsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rgbhsi_div (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [rgbhsi_pkg::NUM_W-1:0]    num,
    input  wire logic [rgbhsi_pkg::DEN_W-1:0]    den,
    output logic      [rgbhsi_pkg::DIV_STEPS-1:0] quo
);
    import rgbhsi_pkg::*;

    logic [DEN_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] low_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS];
    logic [DEN_W-1:0]     den_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DEN_W-1:0]     rem_in;
        logic [DIV_STEPS-1:0] low_in;
        logic [DIV_STEPS-1:0] q_in;
        logic [DEN_W-1:0]     den_in;
        logic [DEN_W:0]       trial;
        logic                 ge;
        logic [DEN_W-1:0]     rem_next;

        if (k == 0) begin : g_first
            assign rem_in = num[NUM_W-1:DIV_STEPS];
            assign low_in = num[DIV_STEPS-1:0];
            assign q_in   = '0;
            assign den_in = den;
        end
        else begin : g_later
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign trial = {rem_in, low_in[DIV_STEPS-1]};
        assign ge    = trial >= {1'b0, den_in};
        always_comb
        begin
            if (ge)
                rem_next = DEN_W'(trial - {1'b0, den_in});
            else
                rem_next = trial[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_in[DIV_STEPS-2:0], 1'b0};
                q_reg[k]   <= {q_in[DIV_STEPS-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = q_reg[DIV_STEPS-1];
endmodule
`default_nettype wire

// File: rtl/rgbhsi_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in 2^-20 degree units.
`default_nettype none
module rgbhsi_cordic (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire rgbhsi_pkg::cord_t   x,
    input  wire rgbhsi_pkg::cord_t   y,
    output rgbhsi_pkg::ang_t         z
);
    import rgbhsi_pkg::*;

    localparam ang_t HALF_TURN = ang_t'(180) <<< ANG_BITS;

    // index 0 is the half-plane fold, 1..CORDIC_STEPS the micro-rotations
    cord_t x_reg [CORDIC_STEPS+1];
    cord_t y_reg [CORDIC_STEPS+1];
    ang_t  z_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x[CW-1])
            begin
                x_reg[0] <= -x;
                y_reg[0] <= -y;
                z_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0] <= x;
                y_reg[0] <= y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        cord_t xs;
        cord_t ys;
        logic  pos;
        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;
        assign pos = !y_reg[i][CW-1] && (y_reg[i] != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (pos)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ang_t'(ATAN_TAB[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ang_t'(ATAN_TAB[i]);
                end
            end
        end
    end

    assign z = z_reg[CORDIC_STEPS];
endmodule
`default_nettype wire

// File: rtl/rgb_to_hsi_pixel.sv
// RGB to HSI pixel converter, top level.
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel as red, green, blue bytes.
//   Output channel (out_valid/out_ready) gives hue (1/2^HUE_FRAC_BITS degree),
//   saturation and intensity (2^FRACTION_BITS = 1.0) and black_pixel.
//   Throughput: one pixel per clock while the receiver takes results.
//   Pipeline: a pixel passes through 27 register stages before out_valid rises:
//   one input stage, 25 middle stages set by the 24-step CORDIC (plus its
//   half-plane fold), with the 25-bit pipelined saturation divider and the
//   intensity reciprocal multiply beside it, one output stage.
//   Gray pixels report hue 90 degrees; black pixels also force saturation
//   to 0 and raise black_pixel.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls with a result pending, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated. Bubbles move on
//   whenever the output register is empty or being taken.
`default_nettype none
module rgb_to_hsi_pixel #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [rgbhsi_pkg::HUE_W-1:0]  hue,
    output logic [rgbhsi_pkg::FRAC_W-1:0] saturation,
    output logic [rgbhsi_pkg::FRAC_W-1:0] intensity,
    output logic             black_pixel
);
    import rgbhsi_pkg::*;

    localparam int   MID    = CORDIC_STEPS + 1;
    localparam int   SH     = ANG_BITS - HUE_FRAC_BITS;
    localparam ang_t FULL   = ang_t'(360) <<< ANG_BITS;
    localparam ang_t HALF   = ang_t'(1) <<< (SH - 1);
    localparam ang_t WRAP   = ang_t'(360) <<< HUE_FRAC_BITS;
    localparam ang_t GRAYH  = ang_t'(90) <<< HUE_FRAC_BITS;
    localparam cord_t SQRT3 = cord_t'(113512);

    // intensity = sum*floor(2^F/765) + (sum*(2^F mod 765) + 382)/765,
    // the last division by reciprocal multiply (exact for operands < 2^20)
    localparam logic [FRAC_W-1:0] INT_Q = FRAC_W'((1 << FRACTION_BITS) / 765);
    localparam logic [9:0]        INT_R = 10'((1 << FRACTION_BITS) % 765);
    localparam logic [20:0]       INT_M = 21'(((1 << 30) + 764) / 765);

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // input stage
    logic signed [10:0] xd;
    logic signed [8:0]  yd;
    logic [9:0]         sum;
    logic [7:0]         mn;
    logic [9:0]         diff;

    assign xd  = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
               - $signed({3'b000, blue});
    assign yd  = $signed({1'b0, green}) - $signed({1'b0, blue});
    assign sum = 10'(red) + 10'(green) + 10'(blue);
    always_comb
    begin
        mn = red;
        if (green < mn)
            mn = green;
        if (blue < mn)
            mn = blue;
    end
    assign diff = sum - 10'(mn) * 10'd3;

    logic             vld_a_reg;
    cord_t            x_a_reg, y_a_reg;
    logic [NUM_W-1:0] nsat_a_reg;
    logic [DEN_W-1:0] den_a_reg;
    logic [19:0]      ni_a_reg;
    logic [FRAC_W-1:0] iq_a_reg;
    logic             gray_a_reg, black_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg     <= cord_t'(xd) <<< 16;
            y_a_reg     <= cord_t'(yd) * SQRT3;
            nsat_a_reg  <= (NUM_W'(diff) << FRACTION_BITS) + NUM_W'(sum >> 1);
            den_a_reg   <= DEN_W'(sum);
            ni_a_reg    <= 20'(sum) * 20'(INT_R) + 20'd382;
            iq_a_reg    <= FRAC_W'(sum) * INT_Q;
            gray_a_reg  <= (red == green) && (green == blue);
            black_a_reg <= (sum == '0);
        end
    end

    // middle stages
    ang_t             z_m;
    logic [DIV_STEPS-1:0] qsat_m;

    rgbhsi_cordic u_cordic (
        .clk (clk), .en (en), .x (x_a_reg), .y (y_a_reg), .z (z_m)
    );
    rgbhsi_div u_div_sat (
        .clk (clk), .en (en), .num (nsat_a_reg), .den (den_a_reg), .quo (qsat_m)
    );

    logic [40:0] iprod;
    assign iprod = {21'd0, ni_a_reg} * {20'd0, INT_M};

    logic vld_m_reg   [MID];
    logic gray_m_reg  [MID];
    logic black_m_reg [MID];
    logic [FRAC_W-1:0] int_m_reg [MID];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gray_m_reg[0]  <= gray_a_reg;
            black_m_reg[0] <= black_a_reg;
            int_m_reg[0]   <= iq_a_reg + FRAC_W'(iprod[40:30]);
            for (int k = 1; k < MID; k++)
            begin
                gray_m_reg[k]  <= gray_m_reg[k-1];
                black_m_reg[k] <= black_m_reg[k-1];
                int_m_reg[k]   <= int_m_reg[k-1];
            end
        end
    end

    // output stage
    ang_t zp, hraw, hwr;
    always_comb
    begin
        zp   = z_m[ZW-1] ? z_m + FULL : z_m;
        hraw = (zp + HALF) >>> SH;
        hwr  = (hraw >= WRAP) ? hraw - WRAP : hraw;
    end

    logic             out_valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [FRAC_W-1:0] sat_reg, int_reg;
    logic             black_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= gray_m_reg[MID-1] ? GRAYH[HUE_W-1:0] : hwr[HUE_W-1:0];
            sat_reg   <= black_m_reg[MID-1] ? '0 : qsat_m[FRAC_W-1:0];
            int_reg   <= int_m_reg[MID-1];
            black_reg <= black_m_reg[MID-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MID; k++)
                vld_m_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg    <= in_valid;
            vld_m_reg[0] <= vld_a_reg;
            for (int k = 1; k < MID; k++)
                vld_m_reg[k] <= vld_m_reg[k-1];
            out_valid_reg <= vld_m_reg[MID-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign hue         = hue_reg;
    assign saturation  = sat_reg;
    assign intensity   = int_reg;
    assign black_pixel = black_reg;
endmodule
`default_nettype wire

// File: rtl/rgbhsi_chk.sv
// Port-level checker for the RGB to HSI converter, with its bind.
`default_nettype none
`include "assert_macros.svh"
module rgbhsi_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [14:0] hue,
    input wire logic [16:0] saturation,
    input wire logic [16:0] intensity,
    input wire logic        black_pixel
);
    // a pending result holds until the transaction completes
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hue) && $stable(saturation) && $stable(intensity) && $stable(black_pixel), "output changed while stalled")
    `ASSERT_IMPL(a_black_sat, out_valid && black_pixel, saturation == '0, "black pixel with nonzero saturation")
    `ASSERT_IMPL(a_black_int, out_valid && black_pixel, intensity == '0, "black pixel with nonzero intensity")
    // input side stalls only while an output transaction is pending
    `ASSERT_IMPL(a_ready, !in_ready, out_valid && !out_ready, "input stalled without output stall")
endmodule

bind rgb_to_hsi_pixel rgbhsi_chk u_rgbhsi_chk (.*);
`default_nettype wire

// File: tb/rgb_to_hsi_pixel_tb.sv
// Self-checking testbench for the RGB to HSI pixel converter.
`timescale 1ns / 1ps
module rgb_to_hsi_pixel_tb;
    import rgbhsi_pkg::*;

    localparam int HFB = 6;
    localparam int FB  = 16;
    localparam int LATENCY = 27;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  h;
        logic [FRAC_W-1:0] s;
        logic [FRAC_W-1:0] i;
        logic              blk;
    } hsi_t;

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_HOLD} phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic [7:0] red = '0, green = '0, blue = '0;
    logic in_ready, out_valid, black_pixel;
    logic [HUE_W-1:0] hue;
    logic [FRAC_W-1:0] saturation, intensity;

    pixel_t pixel_q[$];
    hsi_t   hsi_expected_q[$];
    phase_t phase = PH_FREE;
    int     errors = 0;
    int     checked = 0;
    int     gray_seen = 0;
    int     hold_left = 0;
    longint cycles = 0;

    rgb_to_hsi_pixel #(.HUE_FRAC_BITS(HFB), .FRACTION_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .red(red), .green(green), .blue(blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .hue(hue), .saturation(saturation), .intensity(intensity),
        .black_pixel(black_pixel)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic hsi_t hsi_of(pixel_t p);
        longint r, g, b, x, y, z, xs, ys, sum, mn, diff, hv;
        longint full;
        hsi_t o;
        r = p.r;
        g = p.g;
        b = p.b;
        full = longint'(360) <<< ANG_BITS;
        sum = r + g + b;
        mn = r;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
        if (r == g && g == b)
            hv = 90 <<< HFB;
        else
        begin
            x = (2 * r - g - b) * 65536;
            y = (g - b) * 113512;
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = longint'(180) <<< ANG_BITS;
            end
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                xs = floor_shift(x, k);
                ys = floor_shift(y, k);
                if (y > 0)
                begin
                    x += ys;
                    y -= xs;
                    z += longint'(ATAN_TAB[k]);
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= longint'(ATAN_TAB[k]);
                end
            end
            while (z < 0)
                z += full;
            while (z >= full)
                z -= full;
            hv = (z + (longint'(1) <<< (ANG_BITS - HFB - 1))) >>> (ANG_BITS - HFB);
            if (hv >= (360 <<< HFB))
                hv -= 360 <<< HFB;
        end
        o.h = hv[HUE_W-1:0];
        if (sum == 0)
        begin
            o.s = '0;
            o.blk = 1'b1;
        end
        else
        begin
            diff = sum - 3 * mn;
            o.s = FRAC_W'(((diff <<< FB) + sum / 2) / sum);
            o.blk = 1'b0;
        end
        o.i = FRAC_W'(((sum <<< FB) + 382) / 765);
        return o;
    endfunction

    // driver: offers the head of the pixel queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                hsi_expected_q.push_back(hsi_of(pixel_q.pop_front()));
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_q.size() > 0 &&
                    !((phase == PH_SRC_IDLE && $urandom_range(99) < 68) ||
                      (phase == PH_BOTH && $urandom_range(99) < 9)))
                begin
                    in_valid <= 1'b1;
                    red <= pixel_q[0].r;
                    green <= pixel_q[0].g;
                    blue <= pixel_q[0].b;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // hold-off counter for the long receiver stall
    always @(posedge clk)
    begin
        if (rst_n && phase == PH_HOLD && hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor and receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (hsi_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction h=%0d s=%0d i=%0d b=%0d",
                             $time, hue, saturation, intensity, black_pixel);
                    errors++;
                end
                else
                begin
                    hsi_t e;
                    e = hsi_expected_q.pop_front();
                    checked++;
                    if (e.blk)
                        gray_seen++;
                    if (hue !== e.h)
                    begin
                        $display("%0t: hue exp %0d got %0d", $time, e.h, hue);
                        errors++;
                    end
                    if (saturation !== e.s)
                    begin
                        $display("%0t: saturation exp %0d got %0d", $time, e.s, saturation);
                        errors++;
                    end
                    if (intensity !== e.i)
                    begin
                        $display("%0t: intensity exp %0d got %0d", $time, e.i, intensity);
                        errors++;
                    end
                    if (black_pixel !== e.blk)
                    begin
                        $display("%0t: black_pixel exp %0d got %0d", $time, e.blk,
                                 black_pixel);
                        errors++;
                    end
                end
            end
            if (phase == PH_HOLD && hold_left > 0)
                out_ready <= 1'b0;
            else if (phase == PH_SNK_STALL)
                out_ready <= ($urandom_range(99) >= 68);
            else if (phase == PH_BOTH)
                out_ready <= ($urandom_range(99) >= 9);
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int mode;
        mode = $urandom_range(9);
        p = pixel_t'(24'($urandom));
        if (mode == 0)
        begin
            p.g = p.r;
            p.b = p.r;
        end
        else if (mode == 1)
            p.g = p.b;
        else if (mode == 2)
            p.b = p.r;
        else if (mode == 3)
            p.r = 8'($urandom_range(255, 250));
        return p;
    endfunction

    task automatic drain();
        while (pixel_q.size() > 0 || hsi_expected_q.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic run_phase(phase_t ph, int n);
        phase = ph;
        for (int k = 0; k < n; k++)
            pixel_q.push_back(rand_pixel());
        drain();
    endtask

    initial
    begin
        pixel_t dir[$];
        dir = '{
            '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
            '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
            '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255},
            '{8'd255, 8'd0, 8'd1}, '{8'd255, 8'd1, 8'd0}, '{8'd1, 8'd0, 8'd0},
            '{8'd0, 8'd1, 8'd1}, '{8'd1, 8'd1, 8'd0}, '{8'd170, 8'd85, 8'd85},
            '{8'd85, 8'd170, 8'd170}, '{8'd200, 8'd100, 8'd50}, '{8'd10, 8'd20, 8'd30},
            '{8'd254, 8'd255, 8'd255}, '{8'd1, 8'd0, 8'd1}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir[k])
            pixel_q.push_back(dir[k]);
        drain();
        run_phase(PH_FREE, 400);
        run_phase(PH_SRC_IDLE, 350);
        run_phase(PH_SNK_STALL, 350);
        run_phase(PH_BOTH, 300);
        // long receiver hold-off so the pipeline backs up into in_ready
        hold_left = 200;
        run_phase(PH_HOLD, 200);
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d pixels over free-run, idle, stall and hold-off phases",
                 checked);
        $display("%0d black pixels among them", gray_seen);
        if (errors == 0 && hsi_expected_q.size() == 0 && !out_valid)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/rgbhsi_pkg.sv
rtl/rgbhsi_div.sv
rtl/rgbhsi_cordic.sv
rtl/rgb_to_hsi_pixel.sv
rtl/rgbhsi_chk.sv
tb/rgb_to_hsi_pixel_tb.sv
